// ===== design/streebog_hash_assert.svh =====
`ifndef STREEBOG_HASH_ASSERT_SVH
`define STREEBOG_HASH_ASSERT_SVH
// implication check under reset
`define SBG_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication check under reset
`define SBG_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== design/sbg_pkg.sv =====
package sbg_pkg;

    typedef logic [511:0] blk_t;

    function automatic logic [7:0] pi_sub(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
        8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
        8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
        8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
        8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
        8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
        8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
        8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
        8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
        8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
        8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
        8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
        8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
        8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
        8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
        8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};
        return t[x];
    endfunction

    function automatic logic [63:0] lin_row(input logic [5:0] i);
        logic [63:0] t [64];
        t = '{
        64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
        64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
        64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
        64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
        64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
        64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
        64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
        64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
        64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
        64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
        64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
        64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
        64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
        64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
        64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
        64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};
        return t[i];
    endfunction

    function automatic blk_t round_const(input logic [3:0] r);
        blk_t t [12];
        t = '{
        512'hb1085bda1ecadae9ebcb2f81c0657c1f2f6a76432e45d016714eb88d7585c4fc4b7ce09192676901a2422a08a460d31505767436cc744d23dd806559f2a64507,
        512'h6fa3b58aa99d2f1a4fe39d460f70b5d7f3feea720a232b9861d55e0f16b501319ab5176b12d699585cb561c2db0aa7ca55dda21bd7cbcd56e679047021b19bb7,
        512'hf574dcac2bce2fc70a39fc286a3d843506f15e5f529c1f8bf2ea7514b1297b7bd3e20fe490359eb1c1c93a376062db09c2b6f443867adb31991e96f50aba0ab2,
        512'hef1fdfb3e81566d2f948e1a05d71e4dd488e857e335c3c7d9d721cad685e353fa9d72c82ed03d675d8b71333935203be3453eaa193e837f1220cbebc84e3d12e,
        512'h4bea6bacad4747999a3f410c6ca923637f151c1f1686104a359e35d7800fffbdbfcd1747253af5a3dfff00b723271a167a56a27ea9ea63f5601758fd7c6cfe57,
        512'hae4faeae1d3ad3d96fa4c33b7a3039c02d66c4f95142a46c187f9ab49af08ec6cffaa6b71c9ab7b40af21f66c2bec6b6bf71c57236904f35fa68407a46647d6e,
        512'hf4c70e16eeaac5ec51ac86febf240954399ec6c7e6bf87c9d3473e33197a93c90992abc52d822c3706476983284a05043517454ca23c4af38886564d3a14d493,
        512'h9b1f5b424d93c9a703e7aa020c6e41414eb7f8719c36de1e89b4443b4ddbc49af4892bcb929b069069d18d2bd1a5c42f36acc2355951a8d9a47f0dd4bf02e71e,
        512'h378f5a541631229b944c9ad8ec165fde3a7d3a1b258942243cd955b7e00d0984800a440bdbb2ceb17b2b8a9aa6079c540e38dc92cb1f2a607261445183235adb,
        512'habbedea680056f52382ae548b2e4f3f38941e71cff8a78db1fffe18a1b3361039fe76702af69334b7a1e6c303b7652f43698fad1153bb6c374b4c7fb98459ced,
        512'h7bcd9ed0efc889fb3002c6cd635afe94d8fa6bbbebab076120018021148466798a1d71efea48b9caefbacd1d7d476e98dea2594ac06fd85d6bcaa4cd81f32d1b,
        512'h378ee767f11631bad21380b00449b17acda43c32bcdf1d77f82012d430219f9b5d80ef9d1891cc86e71da4aa88e12852faf417d5d9b21b9948bc924af11bd720};
        return t[r];
    endfunction

endpackage

// ===== design/streebog_hash.sv =====
// channel  | dir | tdata / data                         | tuser
// s_axis   | in  | [7:0] data_byte                      | [0] byte_valid
//          |     | tlast = end_of_message               |
// m_axis   | out | [63:0] digest_word                   | [2:0] word_index
//          |     | tlast = last_word                    |
// cfg      | in  | [0] digest_is_512                    |
// A byte that neither fills the block nor ends the message leaves the block idle, ready for the next byte.
// A block is loaded from the buffer, run through the single LPS unit (25 passes,
// one column a cycle), folded into the chain, then the 64-bit adds update counter and checksum.
// End of message adds two more compressions, then 8 or 4 words.
// The output register holds while m_axis_tready is low; input stalls meanwhile.
// Reset is asynchronous, active low, and restores the zero IV.
module streebog_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import sbg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_KEY, S_MIX, S_RK, S_RX, S_ADD, S_RST, S_OUT
    } state_t;

    typedef enum logic [1:0] {P_FULL, P_LAST, P_N, P_SUM} phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic        d512_reg;
    blk_t        h_reg, n_reg, sig_reg, k_reg, st_reg, m_reg, tmp_reg;
    logic [7:0]  buf_mem [64];
    logic [6:0]  fill_reg;
    logic [2:0]  col_reg;
    logic [3:0]  rnd_reg;
    logic [3:0]  ocnt_reg;
    logic [63:0] odata_reg;
    logic [2:0]  oidx_reg;
    logic        olast_reg, ovalid_reg;
    logic [7:0]  rd_byte_reg;
    logic [6:0]  ld_reg;
    logic        last_reg;
    logic        cn_reg, cs_reg;

    blk_t        lps_src;
    logic [63:0] col_out;
    logic [63:0] sv;
    blk_t        iv;
    logic [6:0]  ld_pos;
    logic [7:0]  ld_byte;
    logic [63:0] n_add;
    logic [64:0] n_sum, s_sum;

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = oidx_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        lps_src = (state_reg == S_MIX) ? st_reg : k_reg;
        for (int j = 0; j < 8; j++)
        begin
            sv[8*j +: 8] = pi_sub(lps_src[64*j + 8*col_reg +: 8]);
        end
        col_out = '0;
        for (int b = 0; b < 64; b++)
        begin
            if (sv[b])
            begin
                col_out = col_out ^ lin_row(6'(63 - b));
            end
        end
    end

    assign iv = d512_reg ? '0 : {64{8'h01}};

    assign ld_pos  = ld_reg - 7'd1;
    assign ld_byte = (ld_pos < fill_reg) ? rd_byte_reg
                   : ((ld_pos == fill_reg) ? 8'h01 : 8'h00);

    always_comb
    begin
        n_add = '0;
        if (col_reg == 3'd0)
        begin
            n_add = (phase_reg == P_FULL) ? 64'd512 : {54'd0, fill_reg, 3'b000};
        end
        n_sum = {1'b0, n_reg[64*col_reg +: 64]} + {1'b0, n_add} + {64'd0, cn_reg};
        s_sum = {1'b0, sig_reg[64*col_reg +: 64]} + {1'b0, m_reg[64*col_reg +: 64]}
              + {64'd0, cs_reg};
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
        begin
            buf_mem[fill_reg[5:0]] <= s_axis_tdata;
        end
        rd_byte_reg <= buf_mem[ld_reg[5:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= P_FULL;
            d512_reg   <= 1'b1;
            h_reg      <= '0;
            n_reg      <= '0;
            sig_reg    <= '0;
            fill_reg   <= '0;
            col_reg    <= '0;
            rnd_reg    <= '0;
            ocnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            oidx_reg   <= '0;
            olast_reg  <= 1'b0;
            ld_reg     <= '0;
            last_reg   <= 1'b0;
            cn_reg     <= 1'b0;
            cs_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        d512_reg <= cfg_data;
                        h_reg    <= cfg_data ? '0 : {64{8'h01}};
                        n_reg    <= '0;
                        sig_reg  <= '0;
                        fill_reg <= '0;
                    end
                    else if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser)
                        begin
                            fill_reg <= fill_reg + 7'd1;
                        end
                        last_reg <= s_axis_tlast;
                        if (s_axis_tuser && fill_reg == 7'd63)
                        begin
                            phase_reg <= P_FULL;
                            ld_reg    <= '0;
                            state_reg <= S_LOAD;
                        end
                        else if (s_axis_tlast)
                        begin
                            phase_reg <= P_LAST;
                            ld_reg    <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    ld_reg <= ld_reg + 7'd1;
                    if (ld_reg != 7'd0)
                    begin
                        m_reg[{ld_pos[5:0], 3'b000} +: 8] <= ld_byte;
                    end
                    if (ld_reg == 7'd64)
                    begin
                        k_reg     <= h_reg ^ n_reg;
                        col_reg   <= '0;
                        state_reg <= S_KEY;
                    end
                end
                S_KEY:
                begin
                    tmp_reg[64*col_reg +: 64] <= col_out;
                    if (col_reg == 3'd7)
                    begin
                        k_reg     <= {col_out, tmp_reg[447:0]};
                        st_reg    <= {col_out, tmp_reg[447:0]} ^ m_reg;
                        rnd_reg   <= '0;
                        state_reg <= S_MIX;
                    end
                    col_reg <= col_reg + 3'd1;
                end
                S_MIX:
                begin
                    tmp_reg[64*col_reg +: 64] <= col_out;
                    if (col_reg == 3'd7)
                    begin
                        st_reg    <= {col_out, tmp_reg[447:0]};
                        k_reg     <= k_reg ^ round_const(rnd_reg);
                        state_reg <= S_RK;
                    end
                    col_reg <= col_reg + 3'd1;
                end
                S_RK:
                begin
                    tmp_reg[64*col_reg +: 64] <= col_out;
                    if (col_reg == 3'd7)
                    begin
                        k_reg   <= {col_out, tmp_reg[447:0]};
                        st_reg  <= st_reg ^ {col_out, tmp_reg[447:0]};
                        rnd_reg <= rnd_reg + 4'd1;
                        state_reg <= (rnd_reg == 4'd11) ? S_RX : S_MIX;
                    end
                    col_reg <= col_reg + 3'd1;
                end
                S_RX:
                begin
                    h_reg   <= h_reg ^ st_reg ^ m_reg;
                    col_reg <= '0;
                    case (phase_reg)
                        P_FULL, P_LAST:
                        begin
                            cn_reg    <= 1'b0;
                            cs_reg    <= 1'b0;
                            state_reg <= S_ADD;
                        end
                        P_N:
                        begin
                            phase_reg <= P_SUM;
                            state_reg <= S_RST;
                        end
                        default:
                        begin
                            ocnt_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                // advance counter and checksum one 64-bit word a cycle
                S_ADD:
                begin
                    n_reg[64*col_reg +: 64]   <= n_sum[63:0];
                    sig_reg[64*col_reg +: 64] <= s_sum[63:0];
                    cn_reg  <= n_sum[64];
                    cs_reg  <= s_sum[64];
                    col_reg <= col_reg + 3'd1;
                    if (col_reg == 3'd7)
                    begin
                        if (phase_reg == P_FULL)
                        begin
                            fill_reg <= '0;
                            if (last_reg)
                            begin
                                last_reg  <= 1'b0;
                                phase_reg <= P_LAST;
                                ld_reg    <= '0;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            phase_reg <= P_N;
                            state_reg <= S_RST;
                        end
                    end
                end
                S_RST:
                begin
                    col_reg <= '0;
                    case (phase_reg)
                        P_N:
                        begin
                            m_reg <= n_reg;
                            k_reg <= h_reg;
                        end
                        default:
                        begin
                            m_reg <= sig_reg;
                            k_reg <= h_reg;
                        end
                    endcase
                    state_reg <= S_KEY;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        if (ocnt_reg == (d512_reg ? 4'd8 : 4'd4))
                        begin
                            ovalid_reg <= 1'b0;
                            h_reg      <= iv;
                            n_reg      <= '0;
                            sig_reg    <= '0;
                            fill_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            ovalid_reg <= 1'b1;
                            odata_reg  <= h_reg[64*(ocnt_reg[2:0] + (d512_reg ? 3'd0 : 3'd4)) +: 64];
                            oidx_reg   <= ocnt_reg[2:0];
                            olast_reg  <= (ocnt_reg + 4'd1) == (d512_reg ? 4'd8 : 4'd4);
                            ocnt_reg   <= ocnt_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/sbg_checker.sv =====
module sbg_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic [63:0] m_axis_tdata,
    input logic cfg_ready
);
`include "streebog_hash_assert.svh"

    `SBG_ASSERT_IMP(a_no_in_during_out, m_axis_tvalid, !s_axis_tready)
    `SBG_ASSERT_IMP(a_in_needs_cfg_ready, s_axis_tready, cfg_ready)
    `SBG_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SBG_ASSERT_NEXT(a_last_done, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule

bind streebog_hash sbg_checker u_sbg_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tdata(m_axis_tdata),
    .cfg_ready(cfg_ready)
);

// ===== tb/streebog_hash_tb.sv =====
module streebog_hash_tb;

    typedef logic [511:0] vec512_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 700;
    localparam int LONG_HOLD = 400;

    localparam logic [7:0] SBOX [256] = '{
        8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
        8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
        8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
        8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
        8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
        8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
        8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
        8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
        8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
        8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
        8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
        8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
        8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
        8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
        8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
        8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};

    localparam logic [63:0] LROW [64] = '{
        64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
        64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
        64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
        64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
        64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
        64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
        64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
        64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
        64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
        64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
        64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
        64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
        64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
        64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
        64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
        64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};

    localparam logic [511:0] RCON [12] = '{
        512'hb1085bda1ecadae9ebcb2f81c0657c1f2f6a76432e45d016714eb88d7585c4fc4b7ce09192676901a2422a08a460d31505767436cc744d23dd806559f2a64507,
        512'h6fa3b58aa99d2f1a4fe39d460f70b5d7f3feea720a232b9861d55e0f16b501319ab5176b12d699585cb561c2db0aa7ca55dda21bd7cbcd56e679047021b19bb7,
        512'hf574dcac2bce2fc70a39fc286a3d843506f15e5f529c1f8bf2ea7514b1297b7bd3e20fe490359eb1c1c93a376062db09c2b6f443867adb31991e96f50aba0ab2,
        512'hef1fdfb3e81566d2f948e1a05d71e4dd488e857e335c3c7d9d721cad685e353fa9d72c82ed03d675d8b71333935203be3453eaa193e837f1220cbebc84e3d12e,
        512'h4bea6bacad4747999a3f410c6ca923637f151c1f1686104a359e35d7800fffbdbfcd1747253af5a3dfff00b723271a167a56a27ea9ea63f5601758fd7c6cfe57,
        512'hae4faeae1d3ad3d96fa4c33b7a3039c02d66c4f95142a46c187f9ab49af08ec6cffaa6b71c9ab7b40af21f66c2bec6b6bf71c57236904f35fa68407a46647d6e,
        512'hf4c70e16eeaac5ec51ac86febf240954399ec6c7e6bf87c9d3473e33197a93c90992abc52d822c3706476983284a05043517454ca23c4af38886564d3a14d493,
        512'h9b1f5b424d93c9a703e7aa020c6e41414eb7f8719c36de1e89b4443b4ddbc49af4892bcb929b069069d18d2bd1a5c42f36acc2355951a8d9a47f0dd4bf02e71e,
        512'h378f5a541631229b944c9ad8ec165fde3a7d3a1b258942243cd955b7e00d0984800a440bdbb2ceb17b2b8a9aa6079c540e38dc92cb1f2a607261445183235adb,
        512'habbedea680056f52382ae548b2e4f3f38941e71cff8a78db1fffe18a1b3361039fe76702af69334b7a1e6c303b7652f43698fad1153bb6c374b4c7fb98459ced,
        512'h7bcd9ed0efc889fb3002c6cd635afe94d8fa6bbbebab076120018021148466798a1d71efea48b9caefbacd1d7d476e98dea2594ac06fd85d6bcaa4cd81f32d1b,
        512'h378ee767f11631bad21380b00449b17acda43c32bcdf1d77f82012d430219f9b5d80ef9d1891cc86e71da4aa88e12852faf417d5d9b21b9948bc924af11bd720};

    function automatic vec512_t mix_columns(input vec512_t a);
        vec512_t r;
        logic [63:0] v;
        logic [63:0] acc;
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8; j++)
                v[8*j +: 8] = SBOX[a[64*j + 8*i +: 8]];
            acc = '0;
            for (int b = 0; b < 64; b++)
                if (v[b])
                    acc ^= LROW[63 - b];
            r[64*i +: 64] = acc;
        end
        return r;
    endfunction

    function automatic vec512_t compress_block(input vec512_t h, input vec512_t n,
                                               input vec512_t m);
        vec512_t k;
        vec512_t st;
        k = mix_columns(h ^ n);
        st = k ^ m;
        for (int r = 0; r < 12; r++)
        begin
            st = mix_columns(st);
            k = mix_columns(k ^ RCON[r]);
            st ^= k;
        end
        return h ^ st ^ m;
    endfunction

    class hash_scoreboard;
        bit          wide;
        vec512_t     chain;
        vec512_t     bit_count;
        vec512_t     checksum;
        logic [7:0]  msg_bytes [64];
        int          fill;
        int          errors;
        int          digests_done;
        digest_word_t expected_words [$];

        function new();
            wide = 1'b1;
            errors = 0;
            digests_done = 0;
            restart();
        endfunction

        function void restart();
            chain = wide ? '0 : {64{8'h01}};
            bit_count = '0;
            checksum = '0;
            fill = 0;
        endfunction

        function void set_size(input bit w);
            wide = w;
            restart();
        endfunction

        function vec512_t padded_block(input int cnt);
            vec512_t m;
            m = '0;
            for (int e = 0; e < 64; e++)
                if (e < cnt)
                    m[8*e +: 8] = msg_bytes[e];
                else if (e == cnt)
                    m[8*e +: 8] = 8'h01;
            return m;
        endfunction

        function void note_item(input logic [7:0] data, input bit valid, input bit last);
            vec512_t m;
            vec512_t zero;
            digest_word_t w;
            int words;
            zero = '0;
            if (valid)
            begin
                msg_bytes[fill] = data;
                fill++;
                if (fill == 64)
                begin
                    m = padded_block(64);
                    chain = compress_block(chain, bit_count, m);
                    bit_count += 512'(512);
                    checksum += m;
                    fill = 0;
                end
            end
            if (!last)
                return;
            m = padded_block(fill);
            chain = compress_block(chain, bit_count, m);
            bit_count += 512'(fill * 8);
            checksum += m;
            chain = compress_block(chain, zero, bit_count);
            chain = compress_block(chain, zero, checksum);
            words = wide ? 8 : 4;
            for (int k = 0; k < words; k++)
            begin
                w.word = chain[64*(8 - words + k) +: 64];
                w.index = k[2:0];
                w.last = (k == words - 1);
                expected_words.push_back(w);
            end
            restart();
        endfunction

        function void check(input logic [63:0] word, input logic [2:0] index, input logic last);
            digest_word_t w;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $time, word, index, last);
                return;
            end
            w = expected_words.pop_front();
            if (word !== w.word)
            begin
                errors++;
                $display("%0t: digest word expected %h actual %h", $time, w.word, word);
            end
            if (index !== w.index)
            begin
                errors++;
                $display("%0t: word index expected %0d actual %0d", $time, w.index, index);
            end
            if (last !== w.last)
            begin
                errors++;
                $display("%0t: last word expected %0b actual %0b", $time, w.last, last);
            end
            if (w.last)
                digests_done++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    hash_scoreboard digest_board;
    int cycles;
    int burst_left;
    int items_sent;
    bit long_hold_done;

    streebog_hash u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        cycles = 0;
        burst_left = 0;
        items_sent = 0;
        long_hold_done = 1'b0;
        digest_board = new();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** streebog_hash: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            digest_board.check(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    // receiver: free stretches, random stalls, one long hold-off
    initial
    begin
        int phase;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (!long_hold_done && m_axis_tvalid && digest_board.digests_done >= 3)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (phase % 96 < 24)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic push_item(input logic [7:0] data, input bit valid, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= valid;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        digest_board.note_item(data, valid, last);
        if (valid || last)
            items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (digest_board.expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input bit w);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        digest_board.set_size(w);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit end_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && i == len - 1);
        end
        if (!end_on_byte || len == 0)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic directed_set();
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic random_messages(input int target);
        int pick;
        int len;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(0, 12);
            else if (pick == 5)
                len = $urandom_range(63, 65);
            else if (pick == 6)
                len = $urandom_range(127, 129);
            else
                len = $urandom_range(13, 40);
            send_message(len, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int plen;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_size(1'b1);
        directed_set();
        random_messages(60);

        // abandon a partial message
        plen = $urandom_range(1, 20);
        for (int i = 0; i < plen; i++)
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        write_size(1'b0);
        directed_set();
        random_messages(120);

        write_size(1'b1);
        random_messages(165);

        write_size(1'b0);
        random_messages(210);

        drain_outputs();
        if (digest_board.errors == 0 && digest_board.expected_words.size() == 0)
            $display("** streebog_hash: PASSED **");
        else
            $display("** streebog_hash: FAILED **");
        $finish;
    end

endmodule
